[design/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// shared types and constants for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int unsigned VALUE_BITS = 64;
	localparam int unsigned CHAR_BITS  = 8;

	localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} sitda_state_t;

	// commands from the sequencer to the shared bcd unit
	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} sitda_ctl_t;

endpackage

[design/sitda_value_if.sv]
// ----------------------------------------------------------------------------
// sitda_value_if
// channel carrying one signed integer item
// ----------------------------------------------------------------------------
interface sitda_value_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [sitda_pkg::VALUE_BITS-1:0]     value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[design/sitda_char_if.sv]
// ----------------------------------------------------------------------------
// sitda_char_if
// channel carrying one ascii character item and its end flag
// ----------------------------------------------------------------------------
interface sitda_char_if;
	logic                               valid;
	logic                               ready;
	logic [sitda_pkg::CHAR_BITS-1:0]    character;
	logic                               last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

[design/sitda_dabble.sv]
// ----------------------------------------------------------------------------
// sitda_dabble
// shared shift and add-3 unit: binary magnitude to packed bcd, one bit a step,
// then shifts the bcd word out a digit at a time, most significant first
// ----------------------------------------------------------------------------
module sitda_dabble #(
	parameter int unsigned MAG_WIDTH = 64,
	parameter int unsigned NDIG      = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sitda_pkg::sitda_ctl_t  ctl,
	input  logic [MAG_WIDTH-1:0]   mag,
	output logic [3:0]             top_digit,
	output logic                   top_zero
);

	localparam int unsigned BCD_WIDTH = 4 * NDIG;

	logic [MAG_WIDTH-1:0] bin_q;
	logic [BCD_WIDTH-1:0] bcd_q;
	logic [BCD_WIDTH-1:0] bcd_adj;

	// add 3 to every digit of five or more before the doubling shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (ctl.load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bcd_q <= {bcd_adj[BCD_WIDTH-2:0], bin_q[MAG_WIDTH-1]};
			bin_q <= {bin_q[MAG_WIDTH-2:0], 1'b0};
		end else if (ctl.shift) begin
			bcd_q <= {bcd_q[BCD_WIDTH-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCD_WIDTH-1 -: 4];
	assign top_zero  = (bcd_q[BCD_WIDTH-1 -: 4] == 4'd0);

endmodule

[design/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a two's complement integer into its decimal ascii text, sign first
//
//   channel  dir   payload               handshake
//   num      sink  value (64, signed)    valid / ready
//   text     src   character (8), last   valid / ready
//
// one item is loaded, run through the bcd unit a bit at a time, stripped of
// its leading zeros, given a sign when negative and sent one digit per
// character; the bcd unit's one-bit shift sets the pace of the conversion.
// num.ready is high only while the sequencer is idle; text stalls hold the
// sequencer in place. reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	sitda_value_if.sink   num,
	sitda_char_if.source  text
);

	// enough decimal digits for VALUE_WIDTH bits
	localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned BCW  = $clog2(VALUE_WIDTH);
	localparam int unsigned DCW  = $clog2(NDIG + 1);

	sitda_pkg::sitda_state_t state_q;
	sitda_pkg::sitda_state_t state_d;
	sitda_pkg::sitda_ctl_t   ctl;

	logic                          neg_q;
	logic [BCW-1:0]                bit_cnt_q;
	logic [DCW-1:0]                dig_cnt_q;
	logic [sitda_pkg::CHAR_BITS-1:0] char_q;
	logic                          last_q;
	logic                          valid_q;

	logic [VALUE_WIDTH-1:0] v;
	logic [VALUE_WIDTH-1:0] mag;
	logic [3:0]             top_digit;
	logic                   top_zero;
	logic                   slot_free;
	logic                   emit_sign;
	logic                   emit_dig;
	logic                   more_lead;
	logic                   conv_done;
	logic                   final_dig;

	assign v   = num.value[VALUE_WIDTH-1:0];
	// unsigned magnitude, so the most negative value stays exact
	assign mag = v[VALUE_WIDTH-1] ? (~v + VALUE_WIDTH'(1)) : v;

	assign slot_free = !valid_q || text.ready;
	assign more_lead = top_zero && (dig_cnt_q > DCW'(1));
	assign conv_done = (bit_cnt_q == BCW'(VALUE_WIDTH - 1));
	assign final_dig = (dig_cnt_q == DCW'(1));

	sitda_dabble #(
		.MAG_WIDTH (VALUE_WIDTH),
		.NDIG      (NDIG)
	) u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.mag       (mag),
		.top_digit (top_digit),
		.top_zero  (top_zero)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				if (num.valid) state_d = sitda_pkg::ST_CONV;
			end
			sitda_pkg::ST_CONV: begin
				if (conv_done) state_d = sitda_pkg::ST_SKIP;
			end
			sitda_pkg::ST_SKIP: begin
				if (!more_lead) state_d = neg_q ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
			end
			sitda_pkg::ST_SIGN: begin
				if (slot_free) state_d = sitda_pkg::ST_EMIT;
			end
			sitda_pkg::ST_EMIT: begin
				if (slot_free && final_dig) state_d = sitda_pkg::ST_IDLE;
			end
			default: begin
				state_d = sitda_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctl       = '0;
		emit_sign = 1'b0;
		emit_dig  = 1'b0;
		num.ready = 1'b0;
		case (state_q)
			sitda_pkg::ST_IDLE: begin
				num.ready = 1'b1;
				ctl.load  = num.valid;
			end
			sitda_pkg::ST_CONV: begin
				ctl.step = 1'b1;
			end
			sitda_pkg::ST_SKIP: begin
				ctl.shift = more_lead;
			end
			sitda_pkg::ST_SIGN: begin
				emit_sign = slot_free;
			end
			sitda_pkg::ST_EMIT: begin
				emit_dig  = slot_free;
				ctl.shift = slot_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sitda_pkg::ST_IDLE;
			neg_q     <= 1'b0;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				neg_q     <= v[VALUE_WIDTH-1];
				bit_cnt_q <= '0;
				dig_cnt_q <= DCW'(NDIG);
			end else begin
				if (ctl.step) bit_cnt_q <= bit_cnt_q + BCW'(1);
				if (ctl.shift) dig_cnt_q <= dig_cnt_q - DCW'(1);
			end
		end
	end

	// output register: the finished item waits here while the next one loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_sign || emit_dig) begin
			valid_q <= 1'b1;
		end else if (text.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_sign) begin
			char_q <= sitda_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (emit_dig) begin
			char_q <= sitda_pkg::CHAR_ZERO + {4'd0, top_digit};
			last_q <= final_dig;
		end
	end

	assign text.valid     = valid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

endmodule
